@@ hdl/selection_sort_engine_core_macros.svh @@
// Assertion macros shared by the checker of the selection sort core.
`ifndef SELECTION_SORT_ENGINE_CORE_MACROS_SVH
`define SELECTION_SORT_ENGINE_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition seen at one edge implies the consequence at the next edge.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sse_pkg.sv @@
// Shared widths and defaults for the selection sort core.
package sse_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned DEF_CAPACITY = 64;

endpackage

@@ hdl/selection_sort_engine_core.sv @@
// Selection sort core: loads a batch, sorts it in place, streams it out ascending.
//
// Input stream (s_*): one signed 32-bit element per request in s_tdata, s_tlast
// marks the last element of the batch. Up to CAPACITY elements are kept; any
// further elements are dropped and the batch is flagged as overflowed.
// Output stream (m_*): the batch in ascending order, m_tlast on the final
// element, m_tuser set on every element of a batch that overflowed.
// Loading takes one cycle per element. After the last element the sort runs
// on a store with one write port and one read port and one shared compare
// unit: a pass over an unsorted prefix of length L reads one element per
// cycle. Each result then goes through read, load and hand over. s_tready
// is low from the last element of a batch until its final result has been
// taken; a stalled receiver simply holds the current result in the output
// register. Reset clears the element count, the overflow flag and the output
// valid; store contents are not cleared.
module selection_sort_engine_core #(
    parameter int unsigned CAPACITY = sse_pkg::DEF_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sse_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                       s_tlast,   // batch_end
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sse_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                       m_tlast,   // final_res
    output logic                       m_tuser    // [0] overflowed
);
    import sse_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_LOAD      = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN      = 3'd1;
    localparam logic [ST_W-1:0] ST_SWAP_A    = 3'd2;
    localparam logic [ST_W-1:0] ST_SWAP_B    = 3'd3;
    localparam logic [ST_W-1:0] ST_EMIT_RD   = 3'd4;
    localparam logic [ST_W-1:0] ST_EMIT_LD   = 3'd5;
    localparam logic [ST_W-1:0] ST_EMIT_WAIT = 3'd6;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [DATA_W-1:0] last_val_reg, last_val_next;
    logic              out_vld_reg, out_vld_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_user_reg, out_user_next;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, rd_data;
    logic              cmp_en, cmp_first;
    logic [DATA_W-1:0] best_val;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W-1:0]  load_cnt, len_m1, count_m1;

    sse_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (rd_data)
    );

    sse_max_unit #(
        .IDX_W (IDX_W)
    ) u_max (
        .aclk     (aclk),
        .en       (cmp_en),
        .first    (cmp_first),
        .data     (rd_data),
        .idx      (rd_idx_reg),
        .best_val (best_val),
        .best_idx (best_idx)
    );

    assign load_cnt = (count_reg < CAP_CNT) ? count_reg + ONE_CNT : count_reg;
    assign len_m1   = len_reg - ONE_CNT;
    assign count_m1 = count_reg - ONE_CNT;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        rd_pend_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        last_val_next = last_val_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_user_next = out_user_reg;
        s_tready      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[IDX_W-1:0];
        mem_wdata     = s_tdata;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg[IDX_W-1:0];
        cmp_en        = 1'b0;
        cmp_first     = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    count_next = load_cnt;
                    if (count_reg < CAP_CNT) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[IDX_W-1:0];
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        len_next   = load_cnt;
                        idx_next   = '0;
                        state_next = (load_cnt > ONE_CNT) ? ST_SCAN : ST_EMIT_RD;
                    end
                end
            end
            ST_SCAN: begin
                // issue reads 0..len-1, the compare unit takes each read data in the cycle after its read
                if (idx_reg < len_reg) begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + ONE_CNT;
                end
                if (rd_pend_reg) begin
                    cmp_en    = 1'b1;
                    cmp_first = (rd_idx_reg == '0);
                    if (CNT_W'(rd_idx_reg) == len_m1) begin
                        last_val_next = rd_data;
                        state_next    = ST_SWAP_A;
                    end
                end
            end
            ST_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = best_idx;
                mem_wdata = last_val_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                mem_we     = 1'b1;
                mem_waddr  = len_m1[IDX_W-1:0];
                mem_wdata  = best_val;
                len_next   = len_m1;
                idx_next   = '0;
                state_next = (len_reg > TWO_CNT) ? ST_SCAN : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                mem_re     = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_vld_next  = 1'b1;
                out_data_next = rd_data;
                out_last_next = (idx_reg == count_m1);
                out_user_next = ovf_reg;
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (m_tready) begin
                    out_vld_next = 1'b0;
                    if (out_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + ONE_CNT;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            rd_pend_reg <= rd_pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        last_val_reg <= last_val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ hdl/sse_store.sv @@
// Element store: one write port, one read port with registered read data.
module sse_store #(
    parameter int unsigned DEPTH  = sse_pkg::DEF_CAPACITY,
    parameter int unsigned ADDR_W = $clog2(sse_pkg::DEF_CAPACITY)
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [sse_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [sse_pkg::DATA_W-1:0] rd_data
);
    import sse_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/sse_max_unit.sv @@
// Shared signed compare unit: tracks the running maximum and its index over a scan.
module sse_max_unit #(
    parameter int unsigned IDX_W = $clog2(sse_pkg::DEF_CAPACITY)
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       first,
    input  logic [sse_pkg::DATA_W-1:0] data,
    input  logic [IDX_W-1:0]           idx,
    output logic [sse_pkg::DATA_W-1:0] best_val,
    output logic [IDX_W-1:0]           best_idx
);
    import sse_pkg::*;

    logic [DATA_W-1:0] best_val_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              take;

    // strictly greater, so the earliest of equal maxima stays
    assign take = first || ($signed(data) > $signed(best_val_reg));

    always_ff @(posedge aclk) begin
        if (en && take) begin
            best_val_reg <= data;
            best_idx_reg <= idx;
        end
    end

    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;

endmodule

@@ hdl/sse_chk.sv @@
// Port-level checker for the selection sort core, bound to the top level.
`include "selection_sort_engine_core_macros.svh"

module sse_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [sse_pkg::DATA_W-1:0] s_tdata,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [sse_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // a stalled result holds still
    `SSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
    // loading and emitting never overlap
    `SSE_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input taken while a result is pending")
    // a non-final element keeps the block loading
    `SSE_ASSERT_NEXT(a_keep_loading, s_tvalid && s_tready && !s_tlast, s_tready && !m_tvalid, "left loading before batch end")
    // after the final result the block is back to loading, nothing left over
    `SSE_ASSERT_NEXT(a_batch_done, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "result after final element")

endmodule

bind selection_sort_engine_core sse_chk u_sse_chk (.*);

@@ test/tb_top.sv @@
// Self-checking bench for the selection sort core: batches in, ascending results checked.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP      = sse_pkg::DEF_CAPACITY;
    localparam int unsigned DW       = sse_pkg::DATA_W;
    localparam int          HOLD_CYC = 600;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
    } elem_req_t;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          ovf;
    } sorted_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata  = '0;
    logic          s_tlast  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          m_tlast;
    logic          m_tuser;

    elem_req_t     elem_q[$];
    sorted_t       sorted_q[$];

    // predictor state
    logic [DW-1:0] sort_mem[CAP];
    int unsigned   sort_cnt  = 0;
    bit            sort_ovf  = 1'b0;

    int            err_cnt   = 0;
    int            tx_idle   = 0;
    int            rx_idle   = 0;
    int            hold_asks = 0;
    int            hold_taken;
    int            hold_left;

    selection_sort_engine_core #(.CAPACITY(CAP)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Append one element; on batch end run the max-to-end selection sort and
    // queue the whole batch ascending.
    task automatic predict_sort(input logic [DW-1:0] v, input logic last);
        int unsigned   len;
        int unsigned   best;
        logic [DW-1:0] tmp;
        if (sort_cnt < CAP) begin
            sort_mem[sort_cnt] = v;
            sort_cnt++;
        end else begin
            sort_ovf = 1'b1;
        end
        if (last) begin
            len = sort_cnt;
            while (len != 0) begin
                best = 0;
                for (int unsigned k = 1; k < len; k++) begin
                    if ($signed(sort_mem[best]) < $signed(sort_mem[k]))
                        best = k;
                end
                tmp                = sort_mem[best];
                sort_mem[best]     = sort_mem[len - 1];
                sort_mem[len - 1]  = tmp;
                len--;
            end
            for (int unsigned k = 0; k < sort_cnt; k++)
                sorted_q.push_back('{sort_mem[k], (k + 1 == sort_cnt), sort_ovf});
            sort_cnt = 0;
            sort_ovf = 1'b0;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        elem_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_sort(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (elem_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
                    nxt = elem_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started on the next valid result after a request for one
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_taken <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asks && m_tvalid) begin
            hold_left  <= HOLD_CYC;
            hold_taken <= hold_taken + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle);
    end

    // result monitor
    always @(posedge aclk) begin
        sorted_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_q.size() == 0) begin
                report_err($sformatf("unexpected result %0d last=%0b ovf=%0b",
                                     $signed(m_tdata), m_tlast, m_tuser));
            end else begin
                want = sorted_q.pop_front();
                if (m_tdata !== want.value)
                    report_err($sformatf("sorted_value %0d, expected %0d",
                                         $signed(m_tdata), $signed(want.value)));
                if (m_tlast !== want.last)
                    report_err($sformatf("final_res %0b, expected %0b", m_tlast, want.last));
                if (m_tuser !== want.ovf)
                    report_err($sformatf("overflowed %0b, expected %0b", m_tuser, want.ovf));
            end
        end
    end

    function automatic logic [DW-1:0] rand_elem();
        // narrow values now and then so that duplicates turn up
        if ($urandom_range(0, 3) == 0)
            return DW'($urandom_range(0, 15)) - DW'(8);
        return $urandom;
    endfunction

    task automatic queue_rand_batch(input int n);
        for (int i = 0; i < n; i++)
            elem_q.push_back('{rand_elem(), (i == n - 1)});
    endtask

    // sender pause: nothing in flight, every result taken
    task automatic wait_quiet();
        while (elem_q.size() != 0 || s_tvalid || sorted_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input int tx, input int rx, input int lead, input bit hold);
        int items;
        int n;
        @(negedge aclk);
        tx_idle = tx;
        rx_idle = rx;
        if (hold)
            hold_asks++;
        queue_rand_batch(lead);
        items = lead;
        while (items < 110) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
            queue_rand_batch(n);
            items += n;
        end
        wait_quiet();
    endtask

    initial begin
        static logic [DW-1:0] dir_vals[25] = '{
            32'h8000_0000,
            32'h7FFF_FFFF,
            32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
            32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
            32'h0000_0005, 32'h0000_0004, 32'h0000_0003, 32'h0000_0002, 32'h0000_0001,
            32'h0000_0007, 32'h0000_0007, 32'h0000_0007
        };
        static bit dir_last[25] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                    0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // single-element batches, extremes with ties, sorted, reversed, all equal
        @(negedge aclk);
        tx_idle = 24;
        rx_idle = 63;
        for (int i = 0; i < 25; i++)
            elem_q.push_back('{dir_vals[i], dir_last[i]});
        wait_quiet();

        // lead batches: overflowing, exactly full, overflowing again
        run_phase(24, 63, 64 + $urandom_range(1, 6), 1'b0);
        run_phase(63, 24, 64, 1'b1);
        run_phase(0, 0, 64 + $urandom_range(1, 6), 1'b0);

        repeat (40) @(negedge aclk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sse_pkg.sv
hdl/sse_store.sv
hdl/sse_max_unit.sv
hdl/selection_sort_engine_core.sv
hdl/sse_chk.sv
test/tb_top.sv
